FILE: sv/l2nc_pkg.sv
// ----------------------------------------------------------------------------
// l2nc_pkg
// Shared types and constants for the L2-norm gradient clipper.
// ----------------------------------------------------------------------------
package l2nc_pkg;

  localparam int unsigned MaxElementsDefault = 64;
  localparam int unsigned FracBits           = 24;

  typedef enum logic [0:0] {
    CfgThreshold = 1'b0,
    CfgEpsilon   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] grad_value;
    logic               last_element;
  } grad_in_t;

  typedef struct packed {
    logic signed [31:0] clipped_value;
    logic               was_scaled;
    logic               last_out;
  } clip_out_t;

  typedef enum logic [2:0] {
    StIdle,
    StSqrt,
    StDiv,
    StEmit
  } state_e;

endpackage

FILE: sv/l2_norm_gradient_clip.sv
// A request that does not close the vector keeps busy high while its square
// is added to the sum, so the requests of a vector cannot be taken back to
// back. The closing request starts a square root and then a restoring divide;
// the N results then follow on consecutive cycles. Busy stays high until the
// cycle after the last result; the receiver cannot stall. Reset clears count
// and sum and sets threshold -1 and epsilon 1; the value store is not cleared.
// ----------------------------------------------------------------------------
// l2_norm_gradient_clip
// Stores a gradient vector, takes its L2 norm and scales it down if needed.
// ----------------------------------------------------------------------------
module l2_norm_gradient_clip
  import l2nc_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  grad_in_t         in_i,
  output logic             result_valid_o,
  output clip_out_t        result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [0:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  localparam int unsigned AW = (MaxElements > 1) ? $clog2(MaxElements) : 1;
  localparam int unsigned CW = $clog2(MaxElements + 1);

  logic signed [31:0] mem_q [MaxElements];
  logic signed [31:0] rd_q;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, idx_q;
  logic [63:0]   sum_q;
  logic signed [31:0] thr_q;
  logic [30:0]   eps_q;
  logic [5:0]    step_q;
  logic [63:0]   rem_q;      // sqrt remainder
  logic [31:0]   root_q;
  logic [63:0]   sx_q;       // radicand shifted out two bits per step
  logic [56:0]   dr_q;       // divide remainder
  logic [55:0]   dq_q;       // dividend / quotient shift register
  logic [32:0]   den_q;
  logic          clip_q;
  logic          sq_pend_q;
  logic          rd_pend_q;
  logic          emit_pend_q;
  logic signed [31:0] pend_val_q;
  logic          accept;

  assign cfg_ready_o = !busy;
  assign accept = start && !busy;
  assign busy = (state_q != StIdle) || sq_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= -32'sd1;
      eps_q <= 31'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgThreshold: thr_q <= cfg_data_i;
        CfgEpsilon:   eps_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // multiplier scales the value read back from the store
  logic signed [32:0] ma;
  logic signed [24:0] mb;
  logic signed [57:0] mp;
  assign ma = {rd_q[31], rd_q};
  assign mb = {1'b0, dq_q[23:0]};
  l2nc_mult u_mult (.clk_i, .a_i(ma), .b_i(mb), .p_o(mp));

  // square the magnitude in the cycle after the request
  logic [31:0] mag_q;
  logic [63:0] sq;
  always_ff @(posedge clk_i) begin
    if (accept)
      mag_q <= in_i.grad_value[31] ? 32'(-in_i.grad_value) : in_i.grad_value;
  end
  assign sq = 64'(mag_q) * 64'(mag_q);

  // sqrt step
  logic [63:0] trial;
  logic [63:0] rem_sh;
  always_comb begin
    rem_sh = {rem_q[61:0], sx_q[63:62]};
    trial  = {30'd0, root_q, 2'b01};
  end

  logic [56:0] dsub;
  always_comb dsub = {dr_q[55:0], dq_q[55]} - {24'd0, den_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept && (in_i.last_element ||
                  cnt_q == CW'(MaxElements - 1))) state_d = StSqrt;
      StSqrt: if (!sq_pend_q && step_q == 6'd32) state_d = StDiv;
      StDiv:  if (step_q == 6'd56) state_d = StEmit;
      StEmit: if (idx_q == cnt_q && !rd_pend_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      sum_q <= '0;
      sq_pend_q <= 1'b0;
      step_q <= '0;
      idx_q <= '0;
      clip_q <= 1'b0;
      rd_pend_q <= 1'b0;
      emit_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sq_pend_q <= accept;
      // read, then multiply, then present; rd_pend_q and emit_pend_q follow the read and the product
      rd_pend_q <= (state_q == StEmit) && (idx_q != cnt_q);
      emit_pend_q <= rd_pend_q;
      if (sq_pend_q) begin
        sum_q <= ((sum_q + sq) < sum_q) ? '1 : sum_q + sq;
      end
      if (accept) cnt_q <= cnt_q + 1'b1;
      unique case (state_q)
        StIdle: begin
          step_q <= '0;
          idx_q <= '0;
        end
        StSqrt: if (!sq_pend_q) begin
          if (step_q == 6'd0) begin
            sx_q <= sum_q;
            rem_q <= '0;
            root_q <= '0;
            step_q <= 6'd1;
          end else begin
            if (rem_sh >= trial) begin
              rem_q <= rem_sh - trial;
              root_q <= {root_q[30:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              root_q <= {root_q[30:0], 1'b0};
            end
            sx_q <= {sx_q[61:0], 2'b00};
            if (step_q == 6'd32) begin
              step_q <= '0;
            end else begin
              step_q <= step_q + 1'b1;
            end
          end
        end
        StDiv: begin
          if (step_q == 6'd0) clip_q <= !thr_q[31] && (root_q > thr_q[31:0]);
          if (step_q == 6'd56) begin
            step_q <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        StEmit: begin
          if (idx_q != cnt_q) idx_q <= idx_q + 1'b1;
          if (state_d == StIdle) begin
            cnt_q <= '0;
            sum_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // sqrt: step 0 loads the radicand, steps 1 to 32 take one root bit each
  // divide: step 0 loads thr<<24 and the divisor, steps 1 to 56 restore
  always_ff @(posedge clk_i) begin
    if (state_q == StDiv) begin
      if (step_q == 6'd0) begin
        dr_q  <= '0;
        dq_q  <= {thr_q[31:0], 24'd0};
        den_q <= 33'(root_q) + 33'(eps_q);
      end else if (!dsub[56]) begin
        dr_q <= dsub;
        dq_q <= {dq_q[54:0], 1'b1};
      end else begin
        dr_q <= {dr_q[55:0], dq_q[55]};
        dq_q <= {dq_q[54:0], 1'b0};
      end
    end
    if (accept) mem_q[cnt_q[AW-1:0]] <= in_i.grad_value;
    rd_q <= mem_q[idx_q[AW-1:0]];
    pend_val_q <= rd_q;
  end

  always_comb begin
    result_valid_o = emit_pend_q;
    result_o.clipped_value = clip_q ? 32'(mp >>> FracBits) : pend_val_q;
    result_o.was_scaled = clip_q;
    result_o.last_out = emit_pend_q && !rd_pend_q;
  end

  property p_busy_no_accept;
    @(posedge clk_i) disable iff (!rst_ni) (state_q != StIdle) |-> busy;
  endproperty
  assert property (p_busy_no_accept) else $error("accept while working");

  property p_emit_in_emit;
    @(posedge clk_i) disable iff (!rst_ni)
      result_valid_o |-> $past(state_q == StEmit);
  endproperty
  assert property (p_emit_in_emit) else $error("result outside emit");

endmodule

FILE: sv/l2nc_mult.sv
// ----------------------------------------------------------------------------
// l2nc_mult
// Registered 33x25 signed multiplier for scaling the stored values.
// ----------------------------------------------------------------------------
module l2nc_mult (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [24:0] b_i,
  output logic signed [57:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= 58'(a_i * b_i);
  end

endmodule

FILE: bench/l2_norm_gradient_clip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2_norm_gradient_clip_checker
// Watches the request, register and result channels of the clipper. Keeps its
// own copy of the vector store, square sum and registers. Predicts the scaled
// vector on each closing request and compares every result with it in order.
// ----------------------------------------------------------------------------
module l2_norm_gradient_clip_checker
  import l2nc_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  grad_in_t   in_i,
  input  logic       result_valid_i,
  input  clip_out_t  result_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [0:0] cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int         pending_o,
  output int         fail_count_o
);

  logic signed [31:0] vec_store [MaxElements];
  logic [63:0]        sq_sum;
  int unsigned        vec_len;
  logic signed [31:0] threshold;
  logic [30:0]        eps;
  clip_out_t          clipped_q [$];
  int                 fails;

  assign pending_o    = clipped_q.size();
  assign fail_count_o = fails;

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x    = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Close the vector: work out norm and scale, queue one result per element.
  task automatic close_vector();
    logic [63:0]        norm;
    logic [63:0]        scale;
    logic signed [63:0] prod;
    logic               clip;
    clip_out_t          res;
    clip  = 1'b0;
    scale = '0;
    if (threshold >= 0) begin
      norm = floor_sqrt(sq_sum);
      if (norm > 64'(threshold)) begin
        clip  = 1'b1;
        scale = (64'(threshold) << FracBits) / (norm + 64'(eps));
      end
    end
    for (int unsigned i = 0; i < vec_len; i++) begin
      prod = 64'(vec_store[i]) * $signed(scale);
      res.clipped_value = clip ? 32'(prod >>> FracBits) : vec_store[i];
      res.was_scaled    = clip;
      res.last_out      = (i + 1 == vec_len);
      clipped_q.push_back(res);
    end
    vec_len = 0;
    sq_sum  = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] mag;
    logic [64:0] total;
    clip_out_t   want;
    if (!rst_ni) begin
      sq_sum    = '0;
      vec_len   = 0;
      threshold = -32'sd1;
      eps       = 31'd1;
      fails     = 0;
      clipped_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_idx_e'(cfg_index_i) == CfgThreshold) threshold = cfg_data_i;
        else if (cfg_idx_e'(cfg_index_i) == CfgEpsilon) eps = cfg_data_i[30:0];
      end
      if (start_i && !busy_i) begin
        mag = (in_i.grad_value < 0) ? -64'(in_i.grad_value) : 64'(in_i.grad_value);
        if (vec_len < MaxElements) begin
          vec_store[vec_len] = in_i.grad_value;
          vec_len++;
        end
        total  = 65'(sq_sum) + 65'(mag * mag);
        sq_sum = total[64] ? '1 : total[63:0];
        if (in_i.last_element || vec_len >= MaxElements) close_vector();
      end
      if (result_valid_i) begin
        if (clipped_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result: %0d scaled=%0b last=%0b",
                     result_i.clipped_value, result_i.was_scaled, result_i.last_out);
        end else begin
          want = clipped_q.pop_front();
          if (result_i !== want) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                       want.clipped_value, want.was_scaled, want.last_out,
                       result_i.clipped_value, result_i.was_scaled, result_i.last_out);
          end
        end
      end
    end
  end

endmodule

FILE: bench/l2_norm_gradient_clip_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2_norm_gradient_clip_tb
// Drives gradient vectors and register writes into the clipper: a directed
// opening, then random vectors under several idling phases and register
// settings. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module l2_norm_gradient_clip_tb;
  import l2nc_pkg::*;

  localparam int unsigned CycleLimit = 300000;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  grad_in_t   in_i;
  logic       result_valid_o;
  clip_out_t  result_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [0:0] cfg_index_i;
  logic [31:0] cfg_data_i;
  int         pending;
  int         fail_count;
  int unsigned cycles;
  int unsigned idle_pct;
  int unsigned sent;

  l2_norm_gradient_clip dut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  l2_norm_gradient_clip_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .in_i,
    .result_valid_i(result_valid_o), .result_i(result_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("l2_norm_gradient_clip_tb NOT OK");
      $finish;
    end
  end

  task automatic send_request(logic signed [31:0] value, logic last);
    logic took;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= '{grad_value: value, last_element: last};
    do begin
      @(negedge clk_i);
      took = !busy;
      @(posedge clk_i);
    end while (!took);
    sent++;
  endtask

  // Hold requests off until every result is out and the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    logic took;
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_grad();
    case ($urandom_range(5))
      0: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
      1: return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
      2: return 32'($signed($urandom_range(1 << 28)) - (1 << 27));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_threshold();
    case ($urandom_range(7))
      0: return 32'hffff_ffff;
      1: return 32'd0;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return $urandom_range(1 << 26);
      default: return $urandom_range(1 << 30);
    endcase
  endfunction

  function automatic logic [31:0] rand_eps();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return 32'h7fff_ffff;
      2: return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_vector();
    int unsigned len;
    logic        fill;
    fill = ($urandom_range(39) == 0);
    len  = fill ? 64 : $urandom_range(1, 10);
    for (int unsigned i = 0; i < len; i++)
      send_request(rand_grad(), fill ? ($urandom_range(1) && i == len - 1)
                                     : (i == len - 1));
  endtask

  initial begin
    cycles      = 0;
    sent        = 0;
    idle_pct    = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgThreshold;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bypass at reset values, extremes pass unchanged
    send_request(32'sh7fff_ffff, 1'b0);
    send_request(32'sh8000_0000, 1'b1);
    // zero threshold: everything scales to zero
    write_reg(CfgThreshold, 32'd0);
    send_request(32'sh0100_0000, 1'b0);
    send_request(-32'sh0000_0003, 1'b1);
    // norm exactly on the threshold: no clipping
    write_reg(CfgThreshold, 32'h0100_0000);
    write_reg(CfgEpsilon, 32'd0);
    send_request(-32'sh0100_0000, 1'b1);
    // clipping of mixed signs, floor rounding on negatives
    send_request(32'sh0300_0000, 1'b0);
    send_request(-32'sh0400_0001, 1'b0);
    send_request(32'sh0000_0001, 1'b1);
    // sum saturation
    write_reg(CfgEpsilon, 32'h7fff_ffff);
    write_reg(CfgThreshold, 32'h7fff_ffff);
    repeat (5) send_request(32'sh8000_0000, 1'b0);
    send_request(32'sh0000_0000, 1'b1);
    // register change inside a vector
    send_request(32'sh0500_0000, 1'b0);
    write_reg(CfgThreshold, 32'h0080_0000);
    send_request(-32'sh0200_0000, 1'b1);
    write_reg(CfgThreshold, 32'h8000_0000);
    send_request(32'sh1234_5678, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 71;
        2: idle_pct = 24;
        default: idle_pct = 0;
      endcase
      while (sent < 14 + 25 * (phase + 1)) begin
        if ($urandom_range(3) == 0)
          write_reg($urandom_range(1) ? CfgThreshold : CfgEpsilon,
                    $urandom_range(1) ? rand_threshold() : rand_eps());
        random_vector();
        if ($urandom_range(9) == 0) drain();
      end
    end
    // make sure a full buffer is seen at least once
    write_reg(CfgThreshold, 32'h0200_0000);
    for (int i = 0; i < 64; i++) send_request(rand_grad(), 1'b0);

    drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0)
      $display("l2_norm_gradient_clip_tb OK");
    else
      $display("l2_norm_gradient_clip_tb NOT OK");
    $finish;
  end

endmodule
